// ----- rtl/core/sdls_pkg.sv -----
`timescale 1ns / 1ps

package sdls_pkg;

    localparam logic OP_RAY  = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

    typedef struct packed {
        logic              operation;
        logic [1:0]        region_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [30:0]       surface_density;
        logic [30:0]       disk_radius;
        logic signed [31:0] alpha_x_in;
        logic signed [31:0] alpha_y_in;
        logic signed [31:0] kappa_in;
        logic signed [31:0] gamma1_in;
        logic signed [31:0] gamma2_in;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] alpha_x_out;
        logic signed [31:0] alpha_y_out;
        logic signed [31:0] kappa_out;
        logic signed [31:0] gamma1_out;
        logic signed [31:0] gamma2_out;
        logic              saturated;
    } t_out_rsp;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [30:0]       sig;
        logic [30:0]       rad;
    } t_disk;

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] ka;
        logic signed [31:0] g1;
        logic signed [31:0] g2;
    } t_ray;

    // One disk evaluation traveling down the pipeline
    typedef struct packed {
        logic              first;
        logic              last;
        logic              act;
        logic              dsat;
        logic              xneg;
        logic              yneg;
        logic              in_disk;
        logic              rzero;
        logic              cneg;
        logic              sneg;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [31:0]       mx;
        logic [31:0]       my;
        logic [30:0]       sig;
        t_ray              ray;
    } t_tok;

    typedef struct packed {
        logic              clip;
        logic signed [31:0] val;
    } t_sat;

    // Clip a wide sum to the 32-bit signed range
    function automatic t_sat sat32(input logic signed [65:0] v);
        t_sat r;
        r.clip = 1'b0;
        r.val  = v[31:0];
        if (v > SAT_MAX) begin
            r.clip = 1'b1;
            r.val  = 32'sh7FFFFFFF;
        end else if (v < SAT_MIN) begin
            r.clip = 1'b1;
            r.val  = 32'sh80000000;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/star_disk_lensing_subtract.sv -----
`timescale 1ns / 1ps

// Disk-compensation stage for lensing rays, signed fixed point.
// Input channel: i_valid / o_stall with i_data; a request is a ray
// (operation = ray) or a table load (operation = load). Output channel:
// o_valid / i_stall with o_data, one response per ray, none per load.
// Configuration: i_cfg_we / i_cfg_wdata sets the active disk count.
// A ray is held in an issue register and sends one evaluation per active
// disk (one when no disk is active) into a pipeline of 9 + FRAC_BITS
// stages: table read, offset clip, squares, r^2 sum, compares, FRAC_BITS
// restoring divider stages, mass product, term products, sign/gating, accumulate.
// While a ray is issued o_stall is high, so no new request is taken until
// its last disk has been read; a load does not raise o_stall. At the
// default FRAC_BITS of 24 the values are Q8.24. The issue unit reads the
// disk table once per cycle while the pipeline is not frozen.
// Reset clears the control state and the disk count; the table itself
// holds garbage until loaded. While i_stall holds a waiting response the
// whole pipeline freezes; the issue register can still take one request.
module star_disk_lensing_subtract #(
    parameter int MAX_REGIONS = 4,
    parameter int FRAC_BITS   = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  sdls_pkg::t_in_req  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output sdls_pkg::t_out_rsp o_data,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_wdata
);

    localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

    // ---------------- configuration and issue ----------------
    logic [2:0]           r_num;
    logic                 r_busy;
    logic [IDX_W-1:0]     r_cnt;
    sdls_pkg::t_in_req    r_ray;

    logic                 w_en;
    logic                 w_in_acc;
    logic [7:0]           w_num8;
    logic [7:0]           w_neff;
    logic                 w_last;
    logic [7:0]           w_ld_idx8;
    logic                 w_ld_we;
    sdls_pkg::t_disk      w_ld_ent;
    sdls_pkg::t_disk      w_ent;
    sdls_pkg::t_tok       w_t0;

    // Freeze every stage while the output holds a response that is stalled
    assign w_en     = !(o_valid && i_stall);
    assign w_in_acc = i_valid && !r_busy;
    assign o_stall  = r_busy;

    assign w_num8 = 8'(r_num);
    assign w_neff = (w_num8 > 8'(MAX_REGIONS)) ? 8'(MAX_REGIONS) : w_num8;
    assign w_last = (w_neff == 8'd0) || (8'(r_cnt) == (w_neff - 8'd1));

    assign w_ld_idx8 = 8'(i_data.region_index);
    assign w_ld_we   = w_in_acc && (i_data.operation == sdls_pkg::OP_LOAD)
                       && (int'(i_data.region_index) < MAX_REGIONS);

    always_comb begin
        w_ld_ent.cx  = i_data.pos_x;
        w_ld_ent.cy  = i_data.pos_y;
        w_ld_ent.sig = i_data.surface_density;
        w_ld_ent.rad = i_data.disk_radius;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num  <= '0;
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_num <= i_cfg_wdata;
            end
            if (w_in_acc && (i_data.operation == sdls_pkg::OP_RAY)) begin
                // take a ray and start sweeping the table from entry zero
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy && w_en) begin
                if (w_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_data.operation == sdls_pkg::OP_RAY)) begin
            r_ray <= i_data;
        end
    end

    sdls_ram #(
        .WIDTH ($bits(sdls_pkg::t_disk)),
        .DEPTH (MAX_REGIONS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ld_we),
        .i_waddr (w_ld_idx8[IDX_W-1:0]),
        .i_wdata (w_ld_ent),
        .i_re    (r_busy && w_en),
        .i_raddr (r_cnt),
        .o_rdata (w_ent)
    );

    // Token for the current disk; a ray with no active disk sends one
    // inactive token that only carries the incoming values
    always_comb begin
        w_t0        = '0;
        w_t0.first  = (r_cnt == '0);
        w_t0.last   = w_last;
        w_t0.act    = (w_neff != 8'd0);
        w_t0.px     = r_ray.pos_x;
        w_t0.py     = r_ray.pos_y;
        w_t0.ray.ax = r_ray.alpha_x_in;
        w_t0.ray.ay = r_ray.alpha_y_in;
        w_t0.ray.ka = r_ray.kappa_in;
        w_t0.ray.g1 = r_ray.gamma1_in;
        w_t0.ray.g2 = r_ray.gamma2_in;
    end

    // ---------------- stage 1: table read ----------------
    logic            r_v1;
    sdls_pkg::t_tok  r_t1;

    // ---------------- stage 2: clipped offsets ----------------
    logic            r_v2;
    sdls_pkg::t_tok  r_t2;
    logic [30:0]     r_rad2;
    sdls_pkg::t_sat  w_dx;
    sdls_pkg::t_sat  w_dy;
    sdls_pkg::t_tok  n_t2;

    always_comb begin
        w_dx = sdls_pkg::sat32(66'(r_t1.px) - 66'(w_ent.cx));
        w_dy = sdls_pkg::sat32(66'(r_t1.py) - 66'(w_ent.cy));
        n_t2      = r_t1;
        n_t2.mx   = w_dx.val[31] ? 32'(-w_dx.val) : 32'(w_dx.val);
        n_t2.my   = w_dy.val[31] ? 32'(-w_dy.val) : 32'(w_dy.val);
        n_t2.xneg = w_dx.val[31];
        n_t2.yneg = w_dy.val[31];
        n_t2.sneg = w_dx.val[31] != w_dy.val[31];
        n_t2.sig  = w_ent.sig;
        n_t2.dsat = r_t1.act && (w_dx.clip || w_dy.clip);
    end

    // ---------------- stage 3: squares ----------------
    logic            r_v3;
    sdls_pkg::t_tok  r_t3;
    logic [63:0]     r_xx3;
    logic [63:0]     r_yy3;
    logic [63:0]     r_xy3;
    logic [63:0]     r_rr3;

    // ---------------- stage 4: r^2 and shear numerators ----------------
    logic            r_v4;
    sdls_pkg::t_tok  r_t4;
    logic [63:0]     r_r2_4;
    logic [63:0]     r_cnum4;
    logic [63:0]     r_snum4;
    logic [63:0]     r_rr4;
    sdls_pkg::t_tok  n_t4;

    // ---------------- stage 5: compares, divider operands ----------------
    logic                r_v5;
    sdls_pkg::t_tok      r_t5;
    logic [63:0]         r_den5;
    logic [2:0][63:0]    r_num5;
    logic [2:0]          r_full5;
    sdls_pkg::t_tok      n_t5;

    // rim point counts as outside; zero r^2 outside adds nothing
    always_comb begin
        n_t4         = r_t3;
        n_t4.cneg    = r_xx3 < r_yy3;
        n_t5         = r_t4;
        n_t5.in_disk = r_r2_4 < r_rr4;
        n_t5.rzero   = r_r2_4 == 64'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= r_busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t1 <= w_t0;

            r_t2   <= n_t2;
            r_rad2 <= w_ent.rad;

            r_t3  <= r_t2;
            r_xx3 <= r_t2.mx * r_t2.mx;
            r_yy3 <= r_t2.my * r_t2.my;
            r_xy3 <= r_t2.mx * r_t2.my;
            r_rr3 <= r_rad2 * r_rad2;

            r_t4      <= n_t4;
            r_r2_4    <= r_xx3 + r_yy3;
            r_cnum4   <= (r_xx3 < r_yy3) ? (r_yy3 - r_xx3) : (r_xx3 - r_yy3);
            r_snum4   <= {r_xy3[62:0], 1'b0};
            r_rr4     <= r_rr3;

            r_t5        <= n_t5;
            r_den5      <= r_r2_4;
            r_num5[0]   <= r_rr4;
            r_num5[1]   <= r_cnum4;
            r_num5[2]   <= r_snum4;
            r_full5[0]  <= r_rr4 >= r_r2_4;
            r_full5[1]  <= r_cnum4 >= r_r2_4;
            r_full5[2]  <= r_snum4 >= r_r2_4;
        end
    end

    // ---------------- divider stages ----------------
    logic [2:0][FRAC_BITS:0] w_quo;
    logic                    r_dv   [FRAC_BITS];
    sdls_pkg::t_tok          r_dtok [FRAC_BITS];

    sdls_fdiv #(
        .FRAC_BITS (FRAC_BITS),
        .LANES     (3)
    ) u_fdiv (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_num5),
        .i_den  (r_den5),
        .i_full (r_full5),
        .o_quo  (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < FRAC_BITS; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_dv[0] <= r_v5;
            for (int k = 1; k < FRAC_BITS; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dtok[0] <= r_t5;
            for (int k = 1; k < FRAC_BITS; k++) begin
                r_dtok[k] <= r_dtok[k-1];
            end
        end
    end

    // ---------------- stage 6: point mass m ----------------
    logic                 r_v6;
    sdls_pkg::t_tok       r_t6;
    logic [30:0]          r_m6;
    logic [FRAC_BITS:0]   r_cm6;
    logic [FRAC_BITS:0]   r_sm6;
    logic [FRAC_BITS+31:0] w_mprod;

    assign w_mprod = r_dtok[FRAC_BITS-1].sig * w_quo[0];

    // ---------------- stage 7: term products ----------------
    logic            r_v7;
    sdls_pkg::t_tok  r_t7;
    logic [62:0]     r_px7;
    logic [62:0]     r_py7;
    logic [62:0]     r_pc7;
    logic [62:0]     r_ps7;
    logic [30:0]     w_mult;

    assign w_mult = r_t6.in_disk ? r_t6.sig : r_m6;

    // ---------------- stage 8: signed, gated terms ----------------
    logic               r_v8;
    sdls_pkg::t_tok     r_t8;
    logic signed [63:0] r_tx8;
    logic signed [63:0] r_ty8;
    logic signed [63:0] r_tc8;
    logic signed [63:0] r_ts8;
    logic [30:0]        r_kt8;

    logic               w_kill;
    logic [62:0]        w_mx;
    logic [62:0]        w_my;
    logic [62:0]        w_mc;
    logic [62:0]        w_ms;

    assign w_kill = !r_t7.act || (!r_t7.in_disk && r_t7.rzero);
    assign w_mx   = r_px7 >> FRAC_BITS;
    assign w_my   = r_py7 >> FRAC_BITS;
    assign w_mc   = r_pc7 >> FRAC_BITS;
    assign w_ms   = r_ps7 >> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
        end else if (w_en) begin
            r_v6 <= r_dv[FRAC_BITS-1];
            r_v7 <= r_v6;
            r_v8 <= r_v7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t6  <= r_dtok[FRAC_BITS-1];
            r_m6  <= w_mprod[FRAC_BITS +: 31];
            r_cm6 <= w_quo[1];
            r_sm6 <= w_quo[2];

            r_t7  <= r_t6;
            r_px7 <= r_t6.mx * w_mult;
            r_py7 <= r_t6.my * w_mult;
            r_pc7 <= r_cm6 * r_m6;
            r_ps7 <= r_sm6 * r_m6;

            r_t8 <= r_t7;
            if (w_kill) begin
                r_tx8 <= '0;
                r_ty8 <= '0;
                r_tc8 <= '0;
                r_ts8 <= '0;
                r_kt8 <= '0;
            end else begin
                r_tx8 <= r_t7.xneg ? -$signed({1'b0, w_mx}) : $signed({1'b0, w_mx});
                r_ty8 <= r_t7.yneg ? -$signed({1'b0, w_my}) : $signed({1'b0, w_my});
                if (r_t7.in_disk) begin
                    r_tc8 <= '0;
                    r_ts8 <= '0;
                    r_kt8 <= r_t7.sig;
                end else begin
                    r_tc8 <= r_t7.cneg ? -$signed({1'b0, w_mc}) : $signed({1'b0, w_mc});
                    r_ts8 <= r_t7.sneg ? -$signed({1'b0, w_ms}) : $signed({1'b0, w_ms});
                    r_kt8 <= '0;
                end
            end
        end
    end

    // ---------------- accumulate in table order ----------------
    sdls_pkg::t_ray     r_acc;
    logic               r_acc_sat;
    logic               r_out_valid;
    sdls_pkg::t_out_rsp r_out;

    sdls_pkg::t_ray     w_base;
    logic               w_base_sat;
    sdls_pkg::t_sat     w_sax;
    sdls_pkg::t_sat     w_say;
    sdls_pkg::t_sat     w_ska;
    sdls_pkg::t_sat     w_sg1;
    sdls_pkg::t_sat     w_sg2;
    sdls_pkg::t_ray     n_acc;
    logic               n_acc_sat;

    always_comb begin
        w_base     = r_t8.first ? r_t8.ray : r_acc;
        w_base_sat = r_t8.first ? 1'b0 : r_acc_sat;
        w_sax = sdls_pkg::sat32(66'(w_base.ax) + 66'(r_tx8));
        w_say = sdls_pkg::sat32(66'(w_base.ay) + 66'(r_ty8));
        w_ska = sdls_pkg::sat32(66'(w_base.ka) - $signed({35'b0, r_kt8}));
        w_sg1 = sdls_pkg::sat32(66'(w_base.g1) + 66'(r_tc8));
        w_sg2 = sdls_pkg::sat32(66'(w_base.g2) + 66'(r_ts8));
        n_acc.ax  = w_sax.val;
        n_acc.ay  = w_say.val;
        n_acc.ka  = w_ska.val;
        n_acc.g1  = w_sg1.val;
        n_acc.g2  = w_sg2.val;
        n_acc_sat = w_base_sat || r_t8.dsat || w_sax.clip || w_say.clip
                    || w_ska.clip || w_sg1.clip || w_sg2.clip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            // hold is covered by w_en; advance loads only a finished ray
            r_out_valid <= r_v8 && r_t8.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_v8) begin
            r_acc     <= n_acc;
            r_acc_sat <= n_acc_sat;
            if (r_t8.last) begin
                r_out.alpha_x_out <= n_acc.ax;
                r_out.alpha_y_out <= n_acc.ay;
                r_out.kappa_out   <= n_acc.ka;
                r_out.gamma1_out  <= n_acc.g1;
                r_out.gamma2_out  <= n_acc.g2;
                r_out.saturated   <= n_acc_sat;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef SYNTH
    a_issue_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && w_en && w_last && !w_in_acc) |=> !r_busy)
        else $error("issue did not stop after last disk");

    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_v8 && r_t8.last))
        else $error("response without a final disk token");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(r_v1) && $stable(r_v8)))
        else $error("pipeline moved while frozen");

    a_idle_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !r_t2.act) |-> !r_t2.dsat)
        else $error("inactive token flagged saturation");
`endif

endmodule

// ----- rtl/core/sdls_ram.sv -----
`timescale 1ns / 1ps

module sdls_ram #(
    parameter int WIDTH = 126,
    parameter int DEPTH = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/sdls_fdiv.sv -----
`timescale 1ns / 1ps

// Pipelined restoring fraction divider: quo = floor(num * 2^F / den),
// capped at one; one quotient bit per stage, LANES numerators, one shared divisor.
module sdls_fdiv #(
    parameter int FRAC_BITS = 24,
    parameter int LANES     = 3
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [LANES-1:0][63:0]            i_num,
    input  logic [63:0]                       i_den,
    input  logic [LANES-1:0]                  i_full,
    output logic [LANES-1:0][FRAC_BITS:0]     o_quo
);

    logic [63:0]                          r_den  [FRAC_BITS];
    logic [LANES-1:0][63:0]               r_rem  [FRAC_BITS];
    logic [LANES-1:0][FRAC_BITS-1:0]      r_q    [FRAC_BITS];
    logic [LANES-1:0]                     r_full [FRAC_BITS];

    logic [63:0]                          w_den_in  [FRAC_BITS];
    logic [LANES-1:0][63:0]               w_rem_in  [FRAC_BITS];
    logic [LANES-1:0][FRAC_BITS-1:0]      w_q_in    [FRAC_BITS];
    logic [LANES-1:0]                     w_full_in [FRAC_BITS];
    logic [LANES-1:0][63:0]               n_rem     [FRAC_BITS];
    logic [LANES-1:0][FRAC_BITS-1:0]      n_q       [FRAC_BITS];

    genvar k;
    generate
        for (k = 0; k < FRAC_BITS; k++) begin : g_stage
            if (k == 0) begin : g_head
                assign w_den_in[k]  = i_den;
                assign w_rem_in[k]  = i_num;
                assign w_q_in[k]    = '0;
                assign w_full_in[k] = i_full;
            end else begin : g_body
                assign w_den_in[k]  = r_den[k-1];
                assign w_rem_in[k]  = r_rem[k-1];
                assign w_q_in[k]    = r_q[k-1];
                assign w_full_in[k] = r_full[k-1];
            end

            always_comb begin
                logic [64:0] shifted;
                logic        ge;
                for (int l = 0; l < LANES; l++) begin
                    shifted = {w_rem_in[k][l], 1'b0};
                    ge      = shifted >= {1'b0, w_den_in[k]};
                    n_rem[k][l] = ge ? 64'(shifted - {1'b0, w_den_in[k]}) : shifted[63:0];
                    n_q[k][l]   = {w_q_in[k][l][FRAC_BITS-2:0], ge};
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[k]  <= w_den_in[k];
                    r_rem[k]  <= n_rem[k];
                    r_q[k]    <= n_q[k];
                    r_full[k] <= w_full_in[k];
                end
            end
        end
    endgenerate

    // Numerator at or above the divisor gives exactly one
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_quo[l] = r_full[FRAC_BITS-1][l] ? {1'b1, {FRAC_BITS{1'b0}}}
                                              : {1'b0, r_q[FRAC_BITS-1][l]};
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

// Tracks the disk table and disk count, predicts each ray response and
// checks responses in order.
class disk_lens_board;
    localparam int NDISK = 4;
    localparam int FB    = 24;

    sdls_pkg::t_out_rsp expected_rays[$];
    logic signed [31:0] cx  [NDISK];
    logic signed [31:0] cy  [NDISK];
    logic [30:0]        sig [NDISK];
    logic [30:0]        rad [NDISK];
    logic [2:0]         disk_count;
    int                 mismatches;

    function new();
        disk_count = '0;
        mismatches = 0;
    endfunction

    function automatic longint clip32(longint v, inout bit f);
        if (v > 64'sd2147483647) begin
            f = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            f = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic logic [63:0] magnitude(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // a * b / 2^FB, truncated toward zero
    function automatic longint scale_tz(longint a, logic [63:0] b);
        logic [63:0] p;
        p = (magnitude(a) * b) >> FB;
        return (a < 0) ? -longint'(p) : longint'(p);
    endfunction

    // floor(num * 2^FB / den), capped at one
    function automatic logic [63:0] ratio_q(logic [63:0] num, logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] q;
        if (num >= den) return 64'd1 << FB;
        rem = {1'b0, num};
        q   = '0;
        for (int i = 0; i < FB; i++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic sdls_pkg::t_out_rsp deflect_ray(sdls_pkg::t_in_req r);
        sdls_pkg::t_out_rsp o;
        bit          sat;
        longint      px, py, ax, ay, ka, g1, g2, dx, dy, c, s;
        logic [63:0] mx, my, xx, yy, r2, rr2, q, m, cm, sm;
        bit          cneg, sneg;
        int          n;
        sat = 0;
        px = r.pos_x;      py = r.pos_y;
        ax = r.alpha_x_in; ay = r.alpha_y_in;
        ka = r.kappa_in;   g1 = r.gamma1_in; g2 = r.gamma2_in;
        n = (disk_count > NDISK) ? NDISK : disk_count;
        for (int i = 0; i < n; i++) begin
            dx  = clip32(px - longint'(cx[i]), sat);
            dy  = clip32(py - longint'(cy[i]), sat);
            mx  = magnitude(dx);
            my  = magnitude(dy);
            xx  = mx * mx;
            yy  = my * my;
            r2  = xx + yy;
            rr2 = 64'(rad[i]) * 64'(rad[i]);
            if (r2 < rr2) begin
                // inside the disk: uniform sheet
                ax = clip32(ax + scale_tz(dx, 64'(sig[i])), sat);
                ay = clip32(ay + scale_tz(dy, 64'(sig[i])), sat);
                ka = clip32(ka - longint'(sig[i]), sat);
            end else if (r2 != 0) begin
                // outside: point mass of Sigma*R^2
                q    = ratio_q(rr2, r2);
                m    = (64'(sig[i]) * q) >> FB;
                cneg = xx < yy;
                sneg = (dx < 0) != (dy < 0);
                ax = clip32(ax + scale_tz(dx, m), sat);
                ay = clip32(ay + scale_tz(dy, m), sat);
                cm = ratio_q(cneg ? yy - xx : xx - yy, r2);
                sm = ratio_q(64'd2 * mx * my, r2);
                c  = cneg ? -longint'(cm) : longint'(cm);
                s  = sneg ? -longint'(sm) : longint'(sm);
                g1 = clip32(g1 + scale_tz(c, m), sat);
                g2 = clip32(g2 + scale_tz(s, m), sat);
            end
        end
        o.alpha_x_out = ax[31:0];
        o.alpha_y_out = ay[31:0];
        o.kappa_out   = ka[31:0];
        o.gamma1_out  = g1[31:0];
        o.gamma2_out  = g2[31:0];
        o.saturated   = sat;
        return o;
    endfunction

    // Apply a load, or queue the predicted response of a ray
    function void note_request(sdls_pkg::t_in_req r);
        if (r.operation == sdls_pkg::OP_LOAD) begin
            cx[r.region_index]  = r.pos_x;
            cy[r.region_index]  = r.pos_y;
            sig[r.region_index] = r.surface_density;
            rad[r.region_index] = r.disk_radius;
        end else begin
            expected_rays.push_back(deflect_ray(r));
        end
    endfunction

    function void check_response(sdls_pkg::t_out_rsp got);
        sdls_pkg::t_out_rsp exp_rsp;
        if (expected_rays.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
            return;
        end
        exp_rsp = expected_rays.pop_front();
        if (got.alpha_x_out !== exp_rsp.alpha_x_out || got.alpha_y_out !== exp_rsp.alpha_y_out
            || got.kappa_out !== exp_rsp.kappa_out || got.gamma1_out !== exp_rsp.gamma1_out
            || got.gamma2_out !== exp_rsp.gamma2_out || got.saturated !== exp_rsp.saturated)
        begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch ax %h/%h ay %h/%h ka %h/%h (exp/got)",
                         exp_rsp.alpha_x_out, got.alpha_x_out, exp_rsp.alpha_y_out,
                         got.alpha_y_out, exp_rsp.kappa_out, got.kappa_out);
                $display("  g1 %h/%h g2 %h/%h sat %b/%b",
                         exp_rsp.gamma1_out, got.gamma1_out, exp_rsp.gamma2_out,
                         got.gamma2_out, exp_rsp.saturated, got.saturated);
            end
        end
    endfunction
endclass

module tb_top;

    localparam int ONE        = 1 << 24;
    localparam int DRAIN_WAIT = 80;
    localparam int CYCLE_CAP  = 600000;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     o_stall;
    sdls_pkg::t_in_req  i_data = '0;
    logic     o_valid;
    logic     i_stall = 1'b0;
    sdls_pkg::t_out_rsp o_data;
    logic     i_cfg_we = 1'b0;
    logic [2:0] i_cfg_wdata = '0;

    disk_lens_board board = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int cycle_count    = 0;

    star_disk_lensing_subtract dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // Receiver: hold off for a long stretch when asked, else stall at random
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall = 1'b1;
            hold_left--;
        end else begin
            i_stall = ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Check every accepted response
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) board.check_response(o_data);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("status: fail");
            $finish;
        end
    end

    // Offer one request; return once it is accepted. Called just after a falling edge.
    task automatic push_request(input sdls_pkg::t_in_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_data  = r;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
            @(negedge i_clk);
        end
        board.note_request(r);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic load_disk(input logic [1:0] idx, input int x, input int y,
                             input logic [30:0] s, input logic [30:0] rr);
        sdls_pkg::t_in_req r;
        r = '0;
        r.operation       = sdls_pkg::OP_LOAD;
        r.region_index    = idx;
        r.pos_x           = x;
        r.pos_y           = y;
        r.surface_density = s;
        r.disk_radius     = rr;
        push_request(r);
    endtask

    task automatic cast_ray(input int x, input int y, input int a);
        sdls_pkg::t_in_req r;
        r = '0;
        r.operation  = sdls_pkg::OP_RAY;
        r.pos_x      = x;
        r.pos_y      = y;
        r.alpha_x_in = a;
        r.alpha_y_in = -a;
        r.kappa_in   = a;
        r.gamma1_in  = a;
        r.gamma2_in  = ~a;
        push_request(r);
    endtask

    // Drain, let loads settle, then write the disk count
    task automatic set_disk_count(input logic [2:0] v);
        while (board.expected_rays.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        board.disk_count = v;
    endtask

    function automatic int near_value();
        return $urandom_range(99) < 10 ? int'($urandom()) : $signed($urandom_range(16 * ONE)) - 8 * ONE;
    endfunction

    function automatic sdls_pkg::t_in_req random_request();
        sdls_pkg::t_in_req r;
        int                k;
        logic [319:0]      noise;
        r = '0;
        if ($urandom_range(99) < 8) begin
            // pure noise: every bit free
            noise = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom(), $urandom(), $urandom()};
            r = noise[$bits(sdls_pkg::t_in_req)-1:0];
            return r;
        end
        r.operation    = ($urandom_range(99) < 15) ? sdls_pkg::OP_LOAD : sdls_pkg::OP_RAY;
        r.region_index = 2'($urandom_range(3));
        if (r.operation == sdls_pkg::OP_LOAD) begin
            r.pos_x = near_value();
            r.pos_y = near_value();
            r.surface_density = 31'(($urandom_range(99) < 15) ? $urandom()
                                                               : $urandom_range(4 * ONE));
            r.disk_radius     = 31'(($urandom_range(99) < 10) ? $urandom()
                                                               : $urandom_range(4 * ONE));
        end else begin
            // aim near a disk center most of the time
            k = $urandom_range(3);
            if ($urandom_range(99) < 70) begin
                r.pos_x = board.cx[k] + $signed($urandom_range(8 * ONE)) - 4 * ONE;
                r.pos_y = board.cy[k] + $signed($urandom_range(8 * ONE)) - 4 * ONE;
            end else begin
                r.pos_x = near_value();
                r.pos_y = near_value();
            end
            r.alpha_x_in = near_value();
            r.alpha_y_in = near_value();
            r.kappa_in   = near_value();
            r.gamma1_in  = near_value();
            r.gamma2_in  = near_value();
        end
        return r;
    endfunction

    initial begin
        logic [2:0] phase_count [4];
        phase_count = '{3'd4, 3'd2, 3'd7, 3'd1};

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // No disks active: rays pass through, extremes of the fields
        cast_ray(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        cast_ray(32'sh80000000, 32'sh80000000, 32'sh80000000);

        // Fill the table before any disk is active
        load_disk(2'd0, 0, 0, 31'(ONE), 31'(ONE));
        load_disk(2'd1, 3 * ONE, -2 * ONE, 31'h7FFFFFFF, 31'd0);
        load_disk(2'd2, 32'sh80000000, 32'sh7FFFFFFF, 31'h12345, 31'h7FFFFFFF);
        load_disk(2'd3, ONE / 4, ONE / 4, 31'(ONE / 16), 31'(ONE / 2));

        set_disk_count(3'd1);
        cast_ray(0, 0, 0);                         // center of a disk: inside
        cast_ray(ONE, 0, 5);                       // on the rim: outside
        cast_ray(0, ONE, -5);                      // on the rim, other axis
        cast_ray(ONE / 2, -ONE / 3, 0);            // inside
        cast_ray(2 * ONE, -2 * ONE, 1000);         // outside, mixed signs
        cast_ray(-3 * ONE, 2 * ONE, 32'sh7FFFFFF0); // outside, sum clips

        set_disk_count(3'd2);
        cast_ray(3 * ONE, -2 * ONE, 0);            // zero radius at zero distance
        cast_ray(5 * ONE, 4 * ONE, 77);            // outside both disks; the dense one has zero radius

        set_disk_count(3'd7);                      // more than the table holds
        cast_ray(32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000);
        cast_ray(32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        cast_ray(ONE / 4, ONE / 4, 0);
        load_disk(2'd3, ONE / 4, ONE / 4, 31'h7FFFFFFF, 31'h7FFFFFFF);
        cast_ray(ONE, -ONE, 32'sh80000001);

        set_disk_count(3'd0);
        cast_ray(ONE, ONE, 12345);

        for (int p = 0; p < 4; p++) begin
            set_disk_count(phase_count[p]);
            case (p)
                0: begin
                    send_idle_pct  = 13;
                    recv_stall_pct = 57;
                end
                1: begin
                    send_idle_pct  = 57;
                    recv_stall_pct = 13;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            // long receiver hold-off while requests keep coming
            if (p == 2) hold_left = 400;
            for (int j = 0; j < 150; j++) push_request(random_request());
        end

        while (board.expected_rays.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (board.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
